// ----- sv/kt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kt_pkg
// Shared constants, types and move tables for the knight's tour stepper.
// ----------------------------------------------------------------------------
package kt_pkg;

    localparam int BOARD_SIZE = 8;                      // 5 .. 8
    localparam int SQUARES    = BOARD_SIZE * BOARD_SIZE;
    localparam int DEPTH      = 64;
    localparam int ADDR_W     = 6;
    localparam int MOVE_W     = 7;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic signed [4:0]  t_coord;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [MOVE_W-1:0]  t_move;

    typedef struct packed {
        t_coord row;
        t_coord col;
        logic   on_board;
        t_addr  index;
    } t_square;

    function automatic t_coord delta_row(input logic [2:0] dir);
        t_coord d;
        unique case (dir)
            3'd0:    d = -5'sd2;
            3'd1:    d = -5'sd1;
            3'd2:    d =  5'sd1;
            3'd3:    d =  5'sd2;
            3'd4:    d =  5'sd2;
            3'd5:    d =  5'sd1;
            3'd6:    d = -5'sd1;
            default: d = -5'sd2;
        endcase
        return d;
    endfunction

    function automatic t_coord delta_col(input logic [2:0] dir);
        t_coord d;
        unique case (dir)
            3'd0:    d =  5'sd1;
            3'd1:    d =  5'sd2;
            3'd2:    d =  5'sd2;
            3'd3:    d =  5'sd1;
            3'd4:    d = -5'sd1;
            3'd5:    d = -5'sd2;
            3'd6:    d = -5'sd2;
            default: d = -5'sd1;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ----- sv/kt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- sv/kt_move_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kt_move_unit
// Shared coordinate unit: adds one knight move to a base square, checks the
// board bounds and forms the board address.
// ----------------------------------------------------------------------------
module kt_move_unit (
    input  wire kt_pkg::t_coord  i_base_row,
    input  wire kt_pkg::t_coord  i_base_col,
    input  wire logic [2:0]      i_dir,
    output kt_pkg::t_square      o_sq
);

    kt_pkg::t_coord w_row;
    kt_pkg::t_coord w_col;

    assign w_row = i_base_row + kt_pkg::delta_row(i_dir);
    assign w_col = i_base_col + kt_pkg::delta_col(i_dir);

    always_comb begin
        o_sq.row      = w_row;
        o_sq.col      = w_col;
        o_sq.on_board = !w_row[4] && (w_row < kt_pkg::t_coord'(kt_pkg::BOARD_SIZE))
                     && !w_col[4] && (w_col < kt_pkg::t_coord'(kt_pkg::BOARD_SIZE));
        o_sq.index    = kt_pkg::t_addr'(w_row[2:0]) * kt_pkg::t_addr'(kt_pkg::BOARD_SIZE)
                      + kt_pkg::t_addr'(w_col[2:0]);
    end

endmodule
`default_nettype wire

// ----- sv/knight_tour_warnsdorff_stepper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knight_tour_warnsdorff_stepper
// Knight's tour builder that places one move per command by Warnsdorff's rule.
//
// Input channel (i_in_valid / o_in_ready) carries one command per transaction:
// opcode start (with start row and column) or advance. Output channel
// (o_out_valid / i_out_ready) returns exactly one result per command: the move
// number placed, the knight's square, and the stuck and complete flags.
//
// Sequence: a start, an ignored start or an advance after the tour has ended
// goes straight to the hand-off state, which loads the output register. A live
// advance first has the sequencer walk 8 candidate moves times 9 board reads
// (the candidate and its 8 onward exits), one read per cycle on the board RAM
// read port; it then drains the read pipeline, decides and writes the board,
// and loads the output register. That single read port paces the scan.
// The block handles one command at a time; o_in_ready is high only when idle.
//
// Reset clears the board valid bits (board reads as all unvisited), puts the
// knight at 0,0 with no moves and marks the tour as over. If the receiver
// stalls, the result sits in the output register and the block still accepts
// the next command; that command's result waits until the register is free.
// ----------------------------------------------------------------------------
module knight_tour_warnsdorff_stepper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_opcode,
    input  wire logic [2:0] i_start_row,
    input  wire logic [2:0] i_start_col,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [6:0]      o_move_number,
    output logic [2:0]      o_row,
    output logic [2:0]      o_col,
    output logic            o_stuck,
    output logic            o_complete
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DECIDE,
        S_DONE
    } t_state;

    localparam logic [3:0] LAST_SLOT = 4'd8;
    localparam logic [2:0] LAST_DIR  = 3'd7;

    t_state r_state, n_state;

    // tour state
    logic [kt_pkg::DEPTH-1:0] r_vld, n_vld;
    logic [2:0]     r_knight_row, n_knight_row;
    logic [2:0]     r_knight_col, n_knight_col;
    kt_pkg::t_move  r_moves, n_moves;
    logic           r_over, n_over;

    // sequencer: candidate direction and slot within the candidate
    logic [2:0]     r_k, n_k;
    logic [3:0]     r_j, n_j;
    kt_pkg::t_coord r_cand_row, n_cand_row;
    kt_pkg::t_coord r_cand_col, n_cand_col;
    kt_pkg::t_addr  r_cand_idx, n_cand_idx;

    // read pipeline tags, aligned with registered RAM data
    logic           r_p_vld, n_p_vld;
    logic           r_p_first, n_p_first;
    logic           r_p_last, n_p_last;
    logic           r_p_on, n_p_on;
    logic           r_rd_vld, n_rd_vld;

    // evaluation
    logic           r_cand_free, n_cand_free;
    logic [3:0]     r_exits, n_exits;
    logic           r_found, n_found;
    logic [3:0]     r_best_cnt, n_best_cnt;
    logic [2:0]     r_best_row, n_best_row;
    logic [2:0]     r_best_col, n_best_col;
    kt_pkg::t_addr  r_best_idx, n_best_idx;

    // pending result and output register
    kt_pkg::t_move  r_res_move, n_res_move;
    logic [2:0]     r_res_row, n_res_row;
    logic [2:0]     r_res_col, n_res_col;
    logic           r_res_stuck, n_res_stuck;
    logic           r_res_complete, n_res_complete;
    logic           r_ovalid, n_ovalid;
    kt_pkg::t_move  r_o_move, n_o_move;
    logic [2:0]     r_o_row, n_o_row;
    logic [2:0]     r_o_col, n_o_col;
    logic           r_o_stuck, n_o_stuck;
    logic           r_o_complete, n_o_complete;

    // shared move unit and board RAM
    kt_pkg::t_coord  w_base_row, w_base_col;
    logic [2:0]      w_dir;
    kt_pkg::t_square w_sq;
    logic            w_we;
    kt_pkg::t_addr   w_waddr;
    kt_pkg::t_move   w_wdata;
    kt_pkg::t_move   w_rdata;

    logic            w_hit, w_free;
    logic [3:0]      w_total;
    logic            w_start_ok;
    kt_pkg::t_addr   w_start_idx;
    logic            w_idle_done, w_idle_stuck;
    kt_pkg::t_move   w_next_move;

    // Slot 0 looks at the candidate from the knight; slots 1..8 at its exits.
    assign w_base_row = (r_j == 4'd0) ? kt_pkg::t_coord'({2'b00, r_knight_row}) : r_cand_row;
    assign w_base_col = (r_j == 4'd0) ? kt_pkg::t_coord'({2'b00, r_knight_col}) : r_cand_col;
    assign w_dir      = (r_j == 4'd0) ? r_k : 3'(r_j - 4'd1);

    kt_move_unit u_move (
        .i_base_row (w_base_row),
        .i_base_col (w_base_col),
        .i_dir      (w_dir),
        .o_sq       (w_sq)
    );

    kt_ram #(
        .WIDTH (kt_pkg::MOVE_W),
        .DEPTH (kt_pkg::DEPTH)
    ) u_board (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_sq.index),
        .o_rdata (w_rdata)
    );

    assign w_start_ok  = ({1'b0, i_start_row} < 4'(kt_pkg::BOARD_SIZE))
                      && ({1'b0, i_start_col} < 4'(kt_pkg::BOARD_SIZE));
    assign w_start_idx = kt_pkg::t_addr'(i_start_row) * kt_pkg::t_addr'(kt_pkg::BOARD_SIZE)
                       + kt_pkg::t_addr'(i_start_col);
    assign w_idle_done  = (r_moves == kt_pkg::t_move'(kt_pkg::SQUARES));
    assign w_idle_stuck = r_over && (r_moves != '0) && !w_idle_done;
    assign w_next_move  = r_moves + kt_pkg::t_move'(1);

    // An entry is visited only if its valid bit is set and it holds a move.
    assign w_hit   = r_rd_vld && (w_rdata != '0);
    assign w_free  = r_p_on && !w_hit;
    assign w_total = r_exits + {3'b000, w_free};

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_vld          = r_vld;
        n_knight_row   = r_knight_row;
        n_knight_col   = r_knight_col;
        n_moves        = r_moves;
        n_over         = r_over;
        n_k            = r_k;
        n_j            = r_j;
        n_cand_row     = r_cand_row;
        n_cand_col     = r_cand_col;
        n_cand_idx     = r_cand_idx;
        n_p_vld        = 1'b0;
        n_p_first      = (r_j == 4'd0);
        n_p_last       = (r_j == LAST_SLOT);
        n_p_on         = w_sq.on_board;
        n_rd_vld       = r_vld[w_sq.index];
        n_cand_free    = r_cand_free;
        n_exits        = r_exits;
        n_found        = r_found;
        n_best_cnt     = r_best_cnt;
        n_best_row     = r_best_row;
        n_best_col     = r_best_col;
        n_best_idx     = r_best_idx;
        n_res_move     = r_res_move;
        n_res_row      = r_res_row;
        n_res_col      = r_res_col;
        n_res_stuck    = r_res_stuck;
        n_res_complete = r_res_complete;
        n_ovalid       = r_ovalid && !i_out_ready;
        n_o_move       = r_o_move;
        n_o_row        = r_o_row;
        n_o_col        = r_o_col;
        n_o_stuck      = r_o_stuck;
        n_o_complete   = r_o_complete;
        w_we           = 1'b0;
        w_waddr        = w_start_idx;
        w_wdata        = kt_pkg::t_move'(1);

        // Evaluate the read that was issued last cycle.
        if (r_p_vld) begin
            if (r_p_first) begin
                n_cand_free = w_free;
                n_exits     = '0;
            end else begin
                n_exits = w_total;
                if (r_p_last && r_cand_free && (!r_found || (w_total < r_best_cnt))) begin
                    n_found    = 1'b1;
                    n_best_cnt = w_total;
                    n_best_row = r_cand_row[2:0];
                    n_best_col = r_cand_col[2:0];
                    n_best_idx = r_cand_idx;
                end
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_move     = '0;
                    n_res_row      = r_knight_row;
                    n_res_col      = r_knight_col;
                    n_res_stuck    = w_idle_stuck;
                    n_res_complete = w_idle_done;
                    n_state        = S_DONE;
                    if (i_opcode == kt_pkg::OP_START) begin
                        if (w_start_ok) begin
                            // clear the board and place move 1
                            n_vld              = '0;
                            n_vld[w_start_idx] = 1'b1;
                            w_we               = 1'b1;
                            n_knight_row       = i_start_row;
                            n_knight_col       = i_start_col;
                            n_moves            = kt_pkg::t_move'(1);
                            n_over             = 1'b0;
                            n_res_move         = kt_pkg::t_move'(1);
                            n_res_row          = i_start_row;
                            n_res_col          = i_start_col;
                            n_res_stuck        = 1'b0;
                            n_res_complete     = 1'b0;
                        end
                    end else if (!r_over) begin
                        n_k     = '0;
                        n_j     = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_p_vld = 1'b1;
                if (r_j == 4'd0) begin
                    n_cand_row = w_sq.row;
                    n_cand_col = w_sq.col;
                    n_cand_idx = w_sq.index;
                end
                if (r_j == LAST_SLOT) begin
                    n_j = '0;
                    if (r_k == LAST_DIR) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_k = r_k + 3'd1;
                    end
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_FLUSH: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (r_found) begin
                    w_we              = 1'b1;
                    w_waddr           = r_best_idx;
                    w_wdata           = w_next_move;
                    n_vld[r_best_idx] = 1'b1;
                    n_moves           = w_next_move;
                    n_knight_row      = r_best_row;
                    n_knight_col      = r_best_col;
                    n_over            = (w_next_move >= kt_pkg::t_move'(kt_pkg::SQUARES));
                    n_res_move        = w_next_move;
                    n_res_row         = r_best_row;
                    n_res_col         = r_best_col;
                    n_res_stuck       = 1'b0;
                    n_res_complete    = (w_next_move >= kt_pkg::t_move'(kt_pkg::SQUARES));
                end else begin
                    n_over         = 1'b1;
                    n_res_move     = '0;
                    n_res_row      = r_knight_row;
                    n_res_col      = r_knight_col;
                    n_res_stuck    = 1'b1;
                    n_res_complete = 1'b0;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid     = 1'b1;
                    n_o_move     = r_res_move;
                    n_o_row      = r_res_row;
                    n_o_col      = r_res_col;
                    n_o_stuck    = r_res_stuck;
                    n_o_complete = r_res_complete;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vld        <= '0;
            r_knight_row <= '0;
            r_knight_col <= '0;
            r_moves      <= '0;
            r_over       <= 1'b1;
            r_p_vld      <= 1'b0;
            r_found      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_k          <= '0;
            r_j          <= '0;
        end else begin
            r_state      <= n_state;
            r_vld        <= n_vld;
            r_knight_row <= n_knight_row;
            r_knight_col <= n_knight_col;
            r_moves      <= n_moves;
            r_over       <= n_over;
            r_p_vld      <= n_p_vld;
            r_found      <= n_found;
            r_ovalid     <= n_ovalid;
            r_k          <= n_k;
            r_j          <= n_j;
        end
        r_cand_row     <= n_cand_row;
        r_cand_col     <= n_cand_col;
        r_cand_idx     <= n_cand_idx;
        r_p_first      <= n_p_first;
        r_p_last       <= n_p_last;
        r_p_on         <= n_p_on;
        r_rd_vld       <= n_rd_vld;
        r_cand_free    <= n_cand_free;
        r_exits        <= n_exits;
        r_best_cnt     <= n_best_cnt;
        r_best_row     <= n_best_row;
        r_best_col     <= n_best_col;
        r_best_idx     <= n_best_idx;
        r_res_move     <= n_res_move;
        r_res_row      <= n_res_row;
        r_res_col      <= n_res_col;
        r_res_stuck    <= n_res_stuck;
        r_res_complete <= n_res_complete;
        r_o_move       <= n_o_move;
        r_o_row        <= n_o_row;
        r_o_col        <= n_o_col;
        r_o_stuck      <= n_o_stuck;
        r_o_complete   <= n_o_complete;
    end

    assign o_out_valid   = r_ovalid;
    assign o_move_number = r_o_move;
    assign o_row         = r_o_row;
    assign o_col         = r_o_col;
    assign o_stuck       = r_o_stuck;
    assign o_complete    = r_o_complete;

    // A placed move advances the move count by exactly one.
    a_move_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_found) |=> (r_moves == $past(r_moves) + kt_pkg::t_move'(1)))
        else $error("move count did not advance by one");

    // The move count never passes the number of squares.
    a_move_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moves <= kt_pkg::t_move'(kt_pkg::SQUARES))
        else $error("move count beyond board size");

    // A live tour has at least one and fewer than all squares visited.
    a_live_tour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_over |-> (r_moves != '0 && r_moves < kt_pkg::t_move'(kt_pkg::SQUARES)))
        else $error("live tour with inconsistent move count");

    // A new result appears only out of the result hand-off state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside hand-off");

    // Board writes never collide with the candidate scan.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE || r_state == S_DECIDE))
        else $error("board write during scan");

endmodule
`default_nettype wire
